>>> src/tick_nanosecond_converter_assert.svh
// assertion macros used by the checker file
`ifndef TICK_NANOSECOND_CONVERTER_ASSERT_SVH
`define TICK_NANOSECOND_CONVERTER_ASSERT_SVH

// checked in the cycle after any cycle with reset held
`define TNC_ASSERT_AFTER_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

// implication checked outside reset
`define TNC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define TNC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/tnc_pkg.sv
// ----------------------------------------------------------------------------
// tnc_pkg
// shared types, codes and the long-division step of the tick converter
// ----------------------------------------------------------------------------
package tnc_pkg;

  localparam logic [1:0] FUNC_TICKS_TO_NS = 2'd0;
  localparam logic [1:0] FUNC_NS_TO_TICKS = 2'd1;
  localparam logic [1:0] FUNC_DIFF_TO_NS  = 2'd2;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_COUNTER  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_FREQ = 8'd1;

  localparam logic [31:0] NS_PER_SEC = 32'd1000000000;
  localparam logic [31:0] FREQ_RESET = 32'd1000000000;

  localparam int unsigned DIV1_STEPS = 64;
  localparam int unsigned DIV2_STEPS = 32;

  // value to divide, divisor, and the factor the quotient is scaled by
  typedef struct packed {
    logic [63:0] num;
    logic [31:0] dsor;
    logic [31:0] mult;
  } item_t;

  // one restoring step: {next remainder, quotient bit}
  function automatic logic [32:0] div_step(input logic [31:0] rem, input logic nbit,
                                           input logic [31:0] dsor);
    logic [32:0] t;
    logic [32:0] diff;
    t    = {rem, nbit};
    diff = t - {1'b0, dsor};
    if (t >= {1'b0, dsor}) begin
      return {diff[31:0], 1'b1};
    end else begin
      return {t[31:0], 1'b0};
    end
  endfunction

endpackage

>>> src/tnc_fifo.sv
// ----------------------------------------------------------------------------
// tnc_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module tnc_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] rdata
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> src/tnc_front.sv
// ----------------------------------------------------------------------------
// tnc_front
// accepts items, maps each to a divide-and-scale job and queues it
// ----------------------------------------------------------------------------
module tnc_front import tnc_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_value_a,
  input  logic [63:0] in_value_b,
  input  logic        use_counter,
  input  logic [31:0] counter_freq_hz,
  input  logic        q_pop,
  output logic        q_empty,
  output item_t       q_item
);

  item_t       job;
  logic [63:0] diff;

  assign diff = in_value_a - in_value_b;

  // pass-through is divide by one, scale by one; zero is scale by zero
  always_comb begin
    job.num  = 64'd0;
    job.dsor = 32'd1;
    job.mult = 32'd1;
    case (in_func)
      FUNC_TICKS_TO_NS, FUNC_DIFF_TO_NS: begin
        job.num = (in_func == FUNC_DIFF_TO_NS) ? diff : in_value_a;
        if (use_counter) begin
          if (counter_freq_hz == 32'd0) begin
            job.mult = 32'd0;
          end else begin
            job.dsor = counter_freq_hz;
            job.mult = NS_PER_SEC;
          end
        end
      end
      FUNC_NS_TO_TICKS: begin
        job.num = in_value_a;
        if (use_counter) begin
          job.dsor = NS_PER_SEC;
          job.mult = counter_freq_hz;
        end
      end
      default: begin
        job.num = 64'd0;
      end
    endcase
  end

  tnc_fifo #(.W($bits(item_t)), .DEPTH(DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .full  (in_full),
    .wdata (job),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_item)
  );

endmodule

>>> src/tnc_back.sv
// ----------------------------------------------------------------------------
// tnc_back
// two long-division pipelines and the final scale-and-add
// ----------------------------------------------------------------------------
module tnc_back import tnc_pkg::*; #(
  parameter int unsigned OUT_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_result
);

  logic adv;
  logic res_full;

  // first division: num / dsor, 64 quotient bits
  logic [63:0] d1_nq_r   [DIV1_STEPS];
  logic [31:0] d1_rem_r  [DIV1_STEPS];
  logic [31:0] d1_dsor_r [DIV1_STEPS];
  logic [31:0] d1_mult_r [DIV1_STEPS];
  logic [DIV1_STEPS-1:0] d1_v_r;

  // remainder times scale
  logic [63:0] b_num2_r;
  logic [63:0] b_q1_r;
  logic [31:0] b_dsor_r;
  logic [31:0] b_mult_r;
  logic        b_v_r;
  logic [63:0] b_prod;

  // second division: quotient fits 32 bits
  logic [31:0] d2_nq_r   [DIV2_STEPS];
  logic [31:0] d2_rem_r  [DIV2_STEPS];
  logic [31:0] d2_dsor_r [DIV2_STEPS];
  logic [31:0] d2_mult_r [DIV2_STEPS];
  logic [63:0] d2_q1_r   [DIV2_STEPS];
  logic [DIV2_STEPS-1:0] d2_v_r;

  logic [63:0] e1_plo_r;
  logic [31:0] e1_q1hi_r;
  logic [31:0] e1_mult_r;
  logic [31:0] e1_q2_r;
  logic        e1_v_r;
  logic [63:0] e1_plo;
  logic [63:0] e2_sum_r;
  logic [31:0] e2_phi_r;
  logic        e2_v_r;
  logic [63:0] e2_phi;
  logic [63:0] e3_res_r;
  logic        e3_v_r;

  // whole pipe moves unless the last result has nowhere to go
  assign adv   = !(e3_v_r && res_full);
  assign q_pop = adv && !q_empty;

  for (genvar k = 0; k < DIV1_STEPS; k++) begin : g_div1
    logic [63:0] nq_in;
    logic [31:0] rem_in;
    logic [31:0] dsor_in;
    logic [31:0] mult_in;
    logic        v_in;
    logic [32:0] st;
    if (k == 0) begin : g_head
      assign nq_in   = q_item.num;
      assign rem_in  = 32'd0;
      assign dsor_in = q_item.dsor;
      assign mult_in = q_item.mult;
      assign v_in    = !q_empty;
    end else begin : g_body
      assign nq_in   = d1_nq_r[k-1];
      assign rem_in  = d1_rem_r[k-1];
      assign dsor_in = d1_dsor_r[k-1];
      assign mult_in = d1_mult_r[k-1];
      assign v_in    = d1_v_r[k-1];
    end
    assign st = div_step(rem_in, nq_in[63], dsor_in);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d1_v_r[k] <= 1'b0;
      end else if (adv) begin
        d1_v_r[k] <= v_in;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        d1_nq_r[k]   <= {nq_in[62:0], st[0]};
        d1_rem_r[k]  <= st[32:1];
        d1_dsor_r[k] <= dsor_in;
        d1_mult_r[k] <= mult_in;
      end
    end
  end

  assign b_prod = d1_rem_r[DIV1_STEPS-1] * d1_mult_r[DIV1_STEPS-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      b_num2_r <= b_prod;
      b_q1_r   <= d1_nq_r[DIV1_STEPS-1];
      b_dsor_r <= d1_dsor_r[DIV1_STEPS-1];
      b_mult_r <= d1_mult_r[DIV1_STEPS-1];
    end
  end

  for (genvar k = 0; k < DIV2_STEPS; k++) begin : g_div2
    logic [31:0] nq_in;
    logic [31:0] rem_in;
    logic [31:0] dsor_in;
    logic [31:0] mult_in;
    logic [63:0] q1_in;
    logic        v_in;
    logic [32:0] st;
    if (k == 0) begin : g_head
      // bits 61:32 seed the remainder as already below the divisor; bits 63:62 are not used
      assign nq_in   = b_num2_r[31:0];
      assign rem_in  = {2'b00, b_num2_r[61:32]};
      assign dsor_in = b_dsor_r;
      assign mult_in = b_mult_r;
      assign q1_in   = b_q1_r;
      assign v_in    = b_v_r;
    end else begin : g_body
      assign nq_in   = d2_nq_r[k-1];
      assign rem_in  = d2_rem_r[k-1];
      assign dsor_in = d2_dsor_r[k-1];
      assign mult_in = d2_mult_r[k-1];
      assign q1_in   = d2_q1_r[k-1];
      assign v_in    = d2_v_r[k-1];
    end
    assign st = div_step(rem_in, nq_in[31], dsor_in);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d2_v_r[k] <= 1'b0;
      end else if (adv) begin
        d2_v_r[k] <= v_in;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        d2_nq_r[k]   <= {nq_in[30:0], st[0]};
        d2_rem_r[k]  <= st[32:1];
        d2_dsor_r[k] <= dsor_in;
        d2_mult_r[k] <= mult_in;
        d2_q1_r[k]   <= q1_in;
      end
    end
  end

  // whole part times scale, split in two 32-bit halves
  assign e1_plo = d2_q1_r[DIV2_STEPS-1][31:0] * d2_mult_r[DIV2_STEPS-1];
  assign e2_phi = e1_q1hi_r * e1_mult_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_plo_r  <= e1_plo;
      e1_q1hi_r <= d2_q1_r[DIV2_STEPS-1][63:32];
      e1_mult_r <= d2_mult_r[DIV2_STEPS-1];
      e1_q2_r   <= d2_nq_r[DIV2_STEPS-1];
      e2_sum_r  <= e1_plo_r + {32'd0, e1_q2_r};
      e2_phi_r  <= e2_phi[31:0];
      e3_res_r  <= e2_sum_r + {e2_phi_r, 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r  <= 1'b0;
      e1_v_r <= 1'b0;
      e2_v_r <= 1'b0;
      e3_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r  <= d1_v_r[DIV1_STEPS-1];
      e1_v_r <= d2_v_r[DIV2_STEPS-1];
      e2_v_r <= e1_v_r;
      e3_v_r <= e2_v_r;
    end
  end

  tnc_fifo #(.W(64), .DEPTH(OUT_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (e3_v_r && adv),
    .full  (res_full),
    .wdata (e3_res_r),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (out_result)
  );

endmodule

>>> src/tick_nanosecond_converter.sv
// ----------------------------------------------------------------------------
// tick_nanosecond_converter
// counter ticks <-> nanoseconds, and tick timestamp difference to nanoseconds
// ----------------------------------------------------------------------------
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------
//   in_      | push / full          | func, value_a, value_b
//   out_     | pop / empty          | result
//   cfg_     | valid / ready        | index, wdata
//
// one item per cycle sustained while the result queue takes results; a result
// shows on the out_ side after passing the front queue, the 64-step and
// 32-step long-division pipelines and the scale-and-add in the back
// reset brings use_counter to 1, the frequency to 1 GHz and empties both queues
// a result waiting at the pipe end while the result queue is full freezes the
// whole back pipeline; once the front queue fills, in_full rises
// configuration is always taken (cfg_ready high)
module tick_nanosecond_converter import tnc_pkg::*; #(
  parameter int unsigned MID_DEPTH = 2,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // item side
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [1:0]            in_func,
  input  logic [63:0]           in_value_a,
  input  logic [63:0]           in_value_b,
  // result side
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [63:0]           out_result,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic        use_counter_r;
  logic [31:0] counter_freq_hz_r;
  logic        q_pop;
  logic        q_empty;
  item_t       q_item;

  assign cfg_ready = 1'b1;

  // unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_counter_r     <= 1'b1;
      counter_freq_hz_r <= FREQ_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_USE_COUNTER:  use_counter_r     <= cfg_wdata[0];
        CFG_COUNTER_FREQ: counter_freq_hz_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // front: classify and queue
  tnc_front #(.DEPTH(MID_DEPTH)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_func         (in_func),
    .in_value_a      (in_value_a),
    .in_value_b      (in_value_b),
    .use_counter     (use_counter_r),
    .counter_freq_hz (counter_freq_hz_r),
    .q_pop           (q_pop),
    .q_empty         (q_empty),
    .q_item          (q_item)
  );

  // back: divide, scale, add, hold results
  tnc_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_result (out_result)
  );

endmodule

>>> src/tnc_checker.sv
// ----------------------------------------------------------------------------
// tnc_checker
// port-level checks of the tick converter, bound to the top level
// ----------------------------------------------------------------------------
`include "tick_nanosecond_converter_assert.svh"

module tnc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [63:0] out_result,
  input logic        cfg_ready
);

  `TNC_ASSERT_AFTER_RST(a_rst_queues, (out_empty && !in_full), "queues not empty after reset")
  `TNC_ASSERT_AFTER_RST(a_rst_latency, ##2 out_empty, "result too soon after reset")
  `TNC_ASSERT_IMPL(a_cfg_ready, 1'b1, cfg_ready, "register write refused")
  `TNC_ASSERT_NEXT(a_hold, (!out_empty && !out_pop), $stable(out_result), "result moved")

endmodule

bind tick_nanosecond_converter tnc_checker u_tnc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_full    (in_full),
  .out_empty  (out_empty),
  .out_pop    (out_pop),
  .out_result (out_result),
  .cfg_ready  (cfg_ready)
);
